// ===== rtl/core/dq_pkg.sv =====
// dq_pkg: shared types and constants of the double-ended queue
// used by dq_cell, dq_chain, double_ended_queue and dq_checker
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DqDepth = 16;
  localparam int unsigned DataW   = 32;

  localparam logic signed [DataW-1:0] EmptyMark = -32'sd999999999;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command shared by all cells of one chain
  typedef struct packed {
    logic shift_in;   // move every entry one cell up, new value into cell 0
    logic shift_out;  // move every entry one cell down
    logic append;     // write new value into the cell at the fill level
  } dq_cell_op_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// dq_cell: one storage cell of a deque chain
// depends on dq_pkg
`timescale 1ns / 1ps

module dq_cell import dq_pkg::*; #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                    clk_i,
  input  dq_cell_op_t             op_i,
  input  logic signed [DataW-1:0] lower_i,
  input  logic signed [DataW-1:0] upper_i,
  input  logic signed [DataW-1:0] new_i,
  input  logic [CNT_W-1:0]        count_i,
  output logic signed [DataW-1:0] data_o
);

  logic signed [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (op_i.shift_in) begin
      data_d = lower_i;
    end else if (op_i.shift_out) begin
      data_d = upper_i;
    end else if (op_i.append && (count_i == CNT_W'(IDX))) begin
      data_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/dq_chain.sv =====
// dq_chain: row of DEPTH cells, entry 0 at the head
// depends on dq_pkg and dq_cell
`timescale 1ns / 1ps

module dq_chain import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  dq_cell_op_t             op_i,
  input  logic signed [DataW-1:0] new_i,
  input  logic [CNT_W-1:0]        count_i,
  output logic signed [DataW-1:0] head_o
);

  logic signed [DataW-1:0] cell_data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = new_i;
    end else begin : g_mid
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_inner
      assign upper = cell_data[g+1];
    end

    dq_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .lower_i (lower),
      .upper_i (upper),
      .new_i   (new_i),
      .count_i (count_i),
      .data_o  (cell_data[g])
    );
  end

  assign head_o = cell_data[0];

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// double_ended_queue: top level of the deque of signed 32-bit values
// depends on dq_pkg and dq_chain
`timescale 1ns / 1ps

// Deque of up to DEPTH signed 32-bit values. Each input beat carries one
// operation (push front, push back, pop front, pop back, query; unused codes
// act as a query) and yields exactly one output beat, in the cycle after
// acceptance, with the popped value, a status and the front, back, count and
// empty flag after the operation. The result sits in an output register; a new
// operation is taken in the same cycle the held result is taken, so the block
// sustains one operation per cycle while the output side is ready. Storage is
// two shift chains of DEPTH cells each, one in front-to-back order and one in
// back-to-front order, so both ends are always read from cell 0. No clearing
// pass follows reset. A push on a full queue is dropped with a full status; a
// pop on an empty queue returns -999999999 with an empty status.

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              kind_i,
  input  logic signed [DataW-1:0] data_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] front_value_o,
  output logic signed [DataW-1:0] back_value_o,
  output logic [4:0]              item_count_o,
  output logic                    is_empty_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] popped_q, popped_d;
  status_e                 status_q, status_d;
  dq_cell_op_t             op_fwd, op_rev;
  logic signed [DataW-1:0] head_fwd, head_rev;
  logic                    accept, full, empty;
  logic [31:0]             count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    op_fwd      = '0;
    op_rev      = '0;
    count_d     = count_q;
    popped_d    = popped_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      out_valid_d = 1'b1;
      popped_d    = EmptyMark;
      status_d    = ST_OK;
      unique case (kind_e'(kind_i))
        KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            op_fwd.shift_in = 1'b1;
            op_rev.append   = 1'b1;
            count_d         = count_q + CntW'(1);
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            op_fwd.append   = 1'b1;
            op_rev.shift_in = 1'b1;
            count_d         = count_q + CntW'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d         = head_fwd;
            op_fwd.shift_out = 1'b1;
            count_d          = count_q - CntW'(1);
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d         = head_rev;
            op_rev.shift_out = 1'b1;
            count_d          = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CntW)
  ) u_chain_fwd (
    .clk_i   (clk_i),
    .op_i    (op_fwd),
    .new_i   (data_in_i),
    .count_i (count_q),
    .head_o  (head_fwd)
  );

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CntW)
  ) u_chain_rev (
    .clk_i   (clk_i),
    .op_i    (op_rev),
    .new_i   (data_in_i),
    .count_i (count_q),
    .head_o  (head_rev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign count_ext      = 32'(count_q);
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = empty ? EmptyMark : head_fwd;
  assign back_value_o   = empty ? EmptyMark : head_rev;
  assign item_count_o   = count_ext[4:0];
  assign is_empty_o     = empty;

endmodule

// ===== rtl/core/dq_checker.sv =====
// dq_checker: port-level checks of double_ended_queue, bound to the top level
// depends on dq_pkg
`timescale 1ns / 1ps

module dq_checker import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [DataW-1:0] popped_value_o,
  input logic [1:0]              status_o,
  input logic [4:0]              item_count_o,
  input logic                    is_empty_o
);

  localparam logic [31:0] DepthW = 32'(DEPTH);

  // every accepted beat shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted beat");

  // input side is never blocked while no result is held
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> item_count_o == 5'd0)
    else $error("empty flag with nonzero count");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> is_empty_o && popped_value_o == EmptyMark)
    else $error("bad result of pop on empty queue");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> item_count_o == DepthW[4:0])
    else $error("full status while not full");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
